@@ rtl/alab_pkg.sv @@
`timescale 1ns / 1ps
package alab_pkg;
	localparam int LUX_W      = 25;
	localparam int TIME_W     = 32;
	localparam int BR_W       = 10;
	localparam int NIT_W      = 12;
	localparam int DIVR_W     = 8;
	localparam int SMC_W      = 17;
	localparam int SS_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int RAD_W      = 30;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int DVD_W      = LUX_W;
	localparam int DVS_W      = NIT_W;
	localparam int PROD_W     = 24;

	localparam logic [BR_W-1:0]   BR_FLOOR_RST       = 10'd5;
	localparam logic [BR_W-1:0]   BRIGHTNESS_MAX_RST = 10'd255;
	localparam logic [NIT_W-1:0]  NIT_MIN_RST        = 12'd2;
	localparam logic [NIT_W-1:0]  NIT_MAX_RST        = 12'd450;
	localparam logic [DIVR_W-1:0] DIVISOR_RST        = 8'd10;
	localparam logic [SMC_W-1:0]  MIN_CHANGE_RST     = 17'd100;
	localparam logic [SS_W-1:0]   STABLE_SEC_RST     = 16'd1;
	localparam logic [BR_W-1:0]   MIN_STEP_RST       = 10'd5;
	localparam logic [BR_W-1:0]   BRIGHTNESS_TOP     = 10'd1023;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BR_FLOOR            = 3'd0,
		CFG_BRIGHTNESS_MAX      = 3'd1,
		CFG_NIT_MIN             = 3'd2,
		CFG_NIT_MAX             = 3'd3,
		CFG_LUX_RATE_DIVISOR    = 3'd4,
		CFG_STABLE_MIN_CHANGE   = 3'd5,
		CFG_STABLE_SECONDS      = 3'd6,
		CFG_MIN_BRIGHTNESS_STEP = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_THR,
		ST_DECIDE,
		ST_SQRT,
		ST_MUL,
		ST_MAP_START,
		ST_MAP_DIV,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;
endpackage

@@ rtl/alab_if.sv @@
`timescale 1ns / 1ps
interface alab_smp_if import alab_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LUX_W-1:0]  lux;
	logic [TIME_W-1:0] now_seconds;
	logic [BR_W-1:0]   current_brightness;
	modport source (output valid, output lux, output now_seconds,
		output current_brightness, input ready);
	modport sink (input valid, input lux, input now_seconds,
		input current_brightness, output ready);
endinterface

interface alab_res_if import alab_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            apply;
	logic [BR_W-1:0] new_brightness;
	modport source (output valid, output apply, output new_brightness, input ready);
	modport sink (input valid, input apply, input new_brightness, output ready);
endinterface

interface alab_cfg_if import alab_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/alab_div.sv @@
`timescale 1ns / 1ps
module alab_div import alab_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] acc_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	// Restoring division: one quotient bit per cycle, shifted into the dividend register.
	assign trial = {rem_q, acc_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;
endmodule

@@ rtl/alab_isqrt.sv @@
`timescale 1ns / 1ps
module alab_isqrt import alab_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);
	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  src_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0]  part;
	logic [REM_W+1:0]  trial;
	logic              fits;

	// Two radicand bits enter per cycle; each cycle settles one root bit.
	assign part  = {rem_q, src_q[RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = part >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			src_q  <= {src_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? REM_W'(part - trial) : part[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

@@ rtl/ambient_light_auto_brightness.sv @@
`timescale 1ns / 1ps
// Channel  Role    Payload
// smp      sink    lux, now_seconds, current_brightness
// res      source  apply, new_brightness
// cfg      sink    index, data (always ready)
//
// A first sample goes through ST_FIRST straight to ST_DONE; any other sample runs the bit-serial
// divider once for the threshold and, when the lux is accepted, the two-bit-per-cycle square root
// and a second divider pass (skipped when the nit limits are equal).
// One sample is in work at a time; the next is taken while a result waits in the output
// register, and a finished result waits until that register is free.
// Reset clears the history and loads the default register values.
module ambient_light_auto_brightness import alab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	alab_smp_if.sink    smp,
	alab_res_if.source  res,
	alab_cfg_if.sink    cfg
);
	state_t state_q, state_d;

	logic [BR_W-1:0]   bmin_q, bmax_q, mstep_q;
	logic [NIT_W-1:0]  nmin_q, nmax_q;
	logic [DIVR_W-1:0] divr_q;
	logic [SMC_W-1:0]  smc_q;
	logic [SS_W-1:0]   ss_q;

	logic              have_q, pend_q;
	logic [LUX_W-1:0]  last_lux_q;
	logic [TIME_W-1:0] last_time_q;

	logic [LUX_W-1:0]  lux_q, prev_q;
	logic [TIME_W-1:0] now_q;
	logic [BR_W-1:0]   cur_q;
	logic [NIT_W-1:0]  nit_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [NIT_W:0]    den_q;
	logic              neg_q;
	logic [BR_W-1:0]   nb_q;
	logic              res_apply_q;
	logic [BR_W-1:0]   res_val_q;
	logic              out_valid_q, out_apply_q;
	logic [BR_W-1:0]   out_val_q;

	unit_ctl_t         div_ctl, sqrt_ctl;
	logic [DVD_W-1:0]  div_dvd, div_quo;
	logic [DVS_W-1:0]  div_dvs;
	logic [ROOT_W-1:0] root;
	logic [RAD_W-1:0]  rad;

	logic              accept;
	logic [LUX_W:0]    thr, thr2, floor_thr;
	logic [LUX_W-1:0]  diff;
	logic              big1, big2, held;
	logic [NIT_W-1:0]  nit_raw, nit_clamp;
	logic signed [BR_W:0]   span;
	logic signed [NIT_W:0]  off;
	logic [PROD_W-1:0] prod_abs;
	logic [NIT_W:0]    den_abs;
	logic signed [DVD_W+2:0] sq, bsum;
	logic [BR_W-1:0]   bsat, mag;
	logic              reject, out_free;

	assign accept   = smp.valid && smp.ready;
	assign out_free = !out_valid_q || res.ready;

	assign thr       = {1'b0, div_quo} + (LUX_W+1)'(256);
	assign floor_thr = {1'b0, smc_q, 8'b0};
	assign thr2      = (thr < floor_thr) ? floor_thr : thr;
	assign diff      = (lux_q >= last_lux_q) ? lux_q - last_lux_q : last_lux_q - lux_q;
	assign big1      = {1'b0, diff} >= thr;
	assign big2      = {1'b0, diff} >= thr2;
	assign held      = (now_q - last_time_q) >= {{(TIME_W-SS_W){1'b0}}, ss_q};
	assign rad       = {1'b0, lux_q, 4'b0} + {2'b0, lux_q, 3'b0} + {5'b0, lux_q};

	assign nit_raw   = {1'b0, root[ROOT_W-1:4]};
	assign nit_clamp = (nit_raw < nmin_q) ? nmin_q : ((nit_raw > nmax_q) ? nmax_q : nit_raw);

	assign span = $signed({1'b0, bmax_q}) - $signed({1'b0, bmin_q});
	assign off  = $signed({1'b0, nit_q}) - $signed({1'b0, nmin_q});

	assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : prod_q;
	assign den_abs  = den_q[NIT_W] ? (NIT_W+1)'(-den_q) : den_q;

	// The quotient of magnitudes is negated afterwards, so it truncates toward zero.
	assign sq   = neg_q ? -$signed({3'b000, div_quo}) : $signed({3'b000, div_quo});
	assign bsum = sq + $signed({{(DVD_W+3-BR_W){1'b0}}, bmin_q});
	assign bsat = bsum[DVD_W+2] ? '0 :
		((bsum > $signed({{(DVD_W+3-BR_W){1'b0}}, BRIGHTNESS_TOP})) ? BRIGHTNESS_TOP :
		bsum[BR_W-1:0]);

	assign mag    = (nb_q >= cur_q) ? nb_q - cur_q : cur_q - nb_q;
	assign reject = (mag < mstep_q) || (lux_q > prev_q && nb_q < cur_q) ||
		(lux_q < prev_q && nb_q > cur_q);

	assign div_dvd = (state_q == ST_IDLE) ? last_lux_q : {1'b0, prod_abs};
	assign div_dvs = (state_q == ST_IDLE) ?
		{4'b0, ((divr_q == '0) ? DIVR_W'(1) : divr_q)} : den_abs[NIT_W-1:0];

	alab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_ctl.start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_ctl.done),
		.quotient (div_quo)
	);

	alab_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_ctl.start),
		.radicand (rad),
		.done     (sqrt_ctl.done),
		.root     (root)
	);

	always_comb begin
		state_d        = state_q;
		div_ctl.start  = 1'b0;
		sqrt_ctl.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (smp.valid) begin
					if (have_q) begin
						div_ctl.start = 1'b1;
						state_d = ST_THR;
					end else begin
						state_d = ST_FIRST;
					end
				end
			end
			ST_FIRST: state_d = ST_DONE;
			ST_THR: begin
				if (div_ctl.done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (pend_q && big2 && held) begin
					sqrt_ctl.start = 1'b1;
					state_d = ST_SQRT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SQRT: begin
				if (sqrt_ctl.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = (nmax_q == nmin_q) ? ST_CHECK : ST_MAP_START;
			ST_MAP_START: begin
				div_ctl.start = 1'b1;
				state_d = ST_MAP_DIV;
			end
			ST_MAP_DIV: begin
				if (div_ctl.done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign smp.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bmin_q      <= BR_FLOOR_RST;
			bmax_q      <= BRIGHTNESS_MAX_RST;
			nmin_q      <= NIT_MIN_RST;
			nmax_q      <= NIT_MAX_RST;
			divr_q      <= DIVISOR_RST;
			smc_q       <= MIN_CHANGE_RST;
			ss_q        <= STABLE_SEC_RST;
			mstep_q     <= MIN_STEP_RST;
			have_q      <= 1'b0;
			pend_q      <= 1'b0;
			last_lux_q  <= '0;
			last_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					CFG_BR_FLOOR:            bmin_q  <= cfg.data[BR_W-1:0];
					CFG_BRIGHTNESS_MAX:      bmax_q  <= cfg.data[BR_W-1:0];
					CFG_NIT_MIN:             nmin_q  <= cfg.data[NIT_W-1:0];
					CFG_NIT_MAX:             nmax_q  <= cfg.data[NIT_W-1:0];
					CFG_LUX_RATE_DIVISOR:    divr_q  <= cfg.data[DIVR_W-1:0];
					CFG_STABLE_MIN_CHANGE:   smc_q   <= cfg.data[SMC_W-1:0];
					CFG_STABLE_SECONDS:      ss_q    <= cfg.data[SS_W-1:0];
					CFG_MIN_BRIGHTNESS_STEP: mstep_q <= cfg.data[BR_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_FIRST) begin
				have_q      <= 1'b1;
				pend_q      <= 1'b1;
				last_lux_q  <= lux_q;
				last_time_q <= now_q;
			end
			if (state_q == ST_DECIDE) begin
				if (!pend_q) begin
					pend_q <= big1;
				end else if (big2 && held) begin
					pend_q      <= 1'b0;
					last_lux_q  <= lux_q;
					last_time_q <= now_q;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lux_q <= smp.lux;
			now_q <= smp.now_seconds;
			cur_q <= smp.current_brightness;
		end
		case (state_q)
			ST_FIRST: begin
				res_apply_q <= 1'b0;
				res_val_q   <= cur_q;
			end
			ST_DECIDE: begin
				prev_q      <= last_lux_q;
				res_apply_q <= 1'b0;
				res_val_q   <= cur_q;
			end
			ST_SQRT: nit_q <= nit_clamp;
			ST_MUL: begin
				prod_q <= PROD_W'(span) * PROD_W'(off);
				den_q  <= $signed({1'b0, nmax_q}) - $signed({1'b0, nmin_q});
				nb_q   <= bmin_q;
			end
			ST_MAP_START: neg_q <= prod_q[PROD_W-1] ^ den_q[NIT_W];
			ST_MAP_DIV: nb_q <= bsat;
			ST_CHECK: begin
				res_apply_q <= !reject;
				res_val_q   <= reject ? cur_q : nb_q;
			end
			ST_DONE: begin
				if (out_free) begin
					out_apply_q <= res_apply_q;
					out_val_q   <= res_val_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid          = out_valid_q;
	assign res.apply          = out_apply_q;
	assign res.new_brightness = out_val_q;
endmodule

@@ rtl/alab_chk.sv @@
`timescale 1ns / 1ps
module alab_chk import alab_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            smp_valid,
	input logic            smp_ready,
	input logic            res_valid,
	input logic            res_ready,
	input logic            res_apply,
	input logic [BR_W-1:0] res_new_brightness
);
	logic [1:0] bal_q;
	logic       smp_acc, res_acc;

	assign smp_acc = smp_valid && smp_ready;
	assign res_acc = res_valid && res_ready;

	// Requests taken minus results delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q <= '0;
		end else begin
			bal_q <= bal_q + {1'b0, smp_acc} - {1'b0, res_acc};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_apply) &&
		$stable(res_new_brightness))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> !smp_ready)
		else $error("request taken while another is in work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> bal_q != 2'd0)
		else $error("result without a request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bal_q == 2'd2 |-> !smp_ready)
		else $error("more than two requests outstanding");
endmodule

bind ambient_light_auto_brightness alab_chk u_alab_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.smp_valid          (smp.valid),
	.smp_ready          (smp.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_apply          (res.apply),
	.res_new_brightness (res.new_brightness)
);
